// ----- design/bes_pkg.sv -----
`default_nettype none

package bes_pkg;

    // Buttons that have pin bits, limits and event bits on the ports.
    localparam int MAX_BUTTONS = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_DELAY      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT_ZERO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT_ONE  = 2'd2;

    localparam logic [15:0] STEP_DELAY_RESET = 16'd10;
    localparam logic [15:0] HOLD_LIMIT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        ST_UP       = 2'd0,
        ST_DOWN     = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } btn_state_t;

    typedef struct packed {
        logic       down;
        logic       hold;
        logic       click;
        btn_state_t state;
    } btn_result_t;

    // Transition table: pressed means the pin level is low.
    function automatic btn_state_t next_state(input btn_state_t cur, input logic pressed);
        btn_state_t nxt;
        nxt = ST_UP;
        case (cur)
            ST_UP:       nxt = pressed ? ST_DOWN : ST_UP;
            ST_DOWN:     nxt = pressed ? ST_HELD : ST_UP;
            ST_HELD:     nxt = pressed ? ST_HELD : ST_RELEASED;
            ST_RELEASED: nxt = pressed ? ST_DOWN : ST_UP;
            default:     nxt = ST_UP;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- design/bes_button.sv -----
`default_nettype none

module bes_button (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic               pressed,
    input  wire logic [15:0]        step_delay,
    input  wire logic [15:0]        hold_limit,
    output bes_pkg::btn_result_t    result
);

    bes_pkg::btn_state_t state_reg, state_next;
    logic                press_active_reg, press_active_next;
    logic [15:0]         timer_reg, timer_next;

    logic [16:0] sum;
    logic [15:0] timer_inc;

    always_comb begin
        state_next        = bes_pkg::next_state(state_reg, pressed);
        sum               = {1'b0, timer_reg} + {1'b0, step_delay};
        timer_inc         = timer_reg;
        if (press_active_reg) begin
            timer_inc = (sum < {1'b0, hold_limit}) ? sum[15:0] : hold_limit;
        end
        timer_next        = timer_inc;
        press_active_next = press_active_reg;
        result.down       = 1'b0;
        result.hold       = 1'b0;
        result.click      = 1'b0;
        result.state      = state_next;
        case (state_next)
            bes_pkg::ST_DOWN: begin
                timer_next        = '0;
                press_active_next = 1'b1;
                result.down       = 1'b1;
            end
            bes_pkg::ST_HELD: begin
                if (timer_inc == hold_limit) begin
                    timer_next  = '0;
                    result.hold = 1'b1;
                end
            end
            bes_pkg::ST_RELEASED: begin
                press_active_next = 1'b0;
                result.click      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bes_pkg::ST_UP;
            press_active_reg <= 1'b0;
            timer_reg        <= '0;
        end else if (step_en) begin
            state_reg        <= state_next;
            press_active_reg <= press_active_next;
            timer_reg        <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/button_event_state_machine.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata[1:0] pin_levels
// m_        out        m_tvalid / m_tready  down, hold, click events, button states
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock unless stalled: item -> input reg -> step logic -> result reg.
// An item yields a result only on a prescaler step (every step_delay + 1 items).
// Reset (aresetn low, synchronous) puts buttons in up, prescaler to 10.
// A stalled result register holds the input register; s_tready stays high
// while the input register is empty or draining. cfg_ready is always high.

module button_event_state_machine #(
    parameter int NUM_BUTTONS = 2
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bes_pkg::IN_TDATA_W-1:0]      s_tdata,   // [1:0] pin_levels
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] down_events, [3:2] hold_events, [5:4] click_events, [9:6] button_states
    output logic [bes_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bes_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bes_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int MODELLED = (NUM_BUTTONS < bes_pkg::MAX_BUTTONS) ?
                              NUM_BUTTONS : bes_pkg::MAX_BUTTONS;

    logic [15:0] step_delay_reg;
    logic [15:0] hold_limit_reg [bes_pkg::MAX_BUTTONS];
    logic [15:0] prescaler_reg, prescaler_next;

    logic                               in_valid_reg;
    logic [bes_pkg::MAX_BUTTONS-1:0]    pins_reg;
    logic                               out_valid_reg;
    logic [bes_pkg::OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    logic advance, consume, step;

    bes_pkg::btn_result_t res [bes_pkg::MAX_BUTTONS];

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign consume   = in_valid_reg && advance;
    assign step      = consume && (prescaler_reg == '0);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_delay_reg    <= bes_pkg::STEP_DELAY_RESET;
            hold_limit_reg[0] <= bes_pkg::HOLD_LIMIT_RESET;
            hold_limit_reg[1] <= bes_pkg::HOLD_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bes_pkg::REG_STEP_DELAY:      step_delay_reg    <= cfg_data;
                bes_pkg::REG_HOLD_LIMIT_ZERO: hold_limit_reg[0] <= cfg_data;
                bes_pkg::REG_HOLD_LIMIT_ONE:  hold_limit_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pins_reg <= s_tdata[bes_pkg::MAX_BUTTONS-1:0];
        end
    end

    always_comb begin
        prescaler_next = prescaler_reg;
        if (consume) begin
            prescaler_next = (prescaler_reg == '0) ? step_delay_reg : prescaler_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescaler_reg <= bes_pkg::STEP_DELAY_RESET;
        end else begin
            prescaler_reg <= prescaler_next;
        end
    end

    for (genvar i = 0; i < bes_pkg::MAX_BUTTONS; i++) begin : g_btn
        if (i < MODELLED) begin : g_on
            bes_button u_btn (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .step_en    (step),
                .pressed    (!pins_reg[i]),
                .step_delay (step_delay_reg),
                .hold_limit (hold_limit_reg[i]),
                .result     (res[i])
            );
        end else begin : g_off
            assign res[i] = '0;
        end
    end

    always_comb begin
        out_data_next = '0;
        for (int i = 0; i < bes_pkg::MAX_BUTTONS; i++) begin
            out_data_next[i]         = res[i].down;
            out_data_next[2 + i]     = res[i].hold;
            out_data_next[4 + i]     = res[i].click;
            out_data_next[6 + 2*i +: 2] = res[i].state;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    a_result_from_step : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(step))
        else $error("result appeared without a prescaler step");

    a_prescaler_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        !consume |=> $stable(prescaler_reg))
        else $error("prescaler moved without a consumed item");

    a_events_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({m_tdata[0], m_tdata[2], m_tdata[4]}) &&
                     $onehot0({m_tdata[1], m_tdata[3], m_tdata[5]}))
        else $error("more than one event for a button in one step");

    a_down_state : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[7:6] == bes_pkg::ST_DOWN)
        else $error("down event without down state");

endmodule

`default_nettype wire
